// ----- hw/rtl/dslim_pkg.sv -----
// dslim_pkg: shared constants, register indexes and word types of the
// delimiter splitter. No dependencies; imported by every RTL file of the block.
`timescale 1ns / 1ps
`default_nettype none

package dslim_pkg;

    // Delimiter geometry
    localparam int MAX_DELIMITER = 8;
    localparam int BYTE_W        = 8;
    localparam int DELIM_W       = MAX_DELIMITER * BYTE_W;
    localparam int LEN_W         = 4;
    localparam int LIMIT_W       = 16;
    localparam int FILL_W        = 4;
    localparam int WIN_IDX_W     = 3;
    localparam int CFG_IDX_W     = 2;

    localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_DELIMITER);
    localparam logic [LIMIT_W-1:0] SPLIT_SAT = {LIMIT_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELIM_BYTES  = 2'd0,
        REG_DELIM_LENGTH = 2'd1,
        REG_SPLIT_LIMIT  = 2'd2
    } cfg_reg_t;

    // Settings seen by the splitting logic (length already clamped to 1..8)
    typedef struct packed {
        logic [DELIM_W-1:0] delim;
        logic [LEN_W-1:0]   len;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    // One result word
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              piece_end;
        logic              stream_end;
    } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dslim_cfg.sv -----
// dslim_cfg: configuration register file of the delimiter splitter.
// Depends on dslim_pkg; clamps the delimiter length before use.
`timescale 1ns / 1ps
`default_nettype none

module dslim_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dslim_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dslim_pkg::DELIM_W-1:0]   cfg_data,
    output dslim_pkg::cfg_t                      cfg
);
    import dslim_pkg::*;

    logic [DELIM_W-1:0] delim_reg, delim_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        delim_next = delim_reg;
        len_next   = len_reg;
        limit_next = limit_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DELIM_BYTES:  delim_next = cfg_data;
                REG_DELIM_LENGTH: len_next   = cfg_data[LEN_W-1:0];
                REG_SPLIT_LIMIT:  limit_next = cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= '0;
            len_reg   <= LEN_W'(1);
            limit_reg <= '0;
        end
        else
        begin
            delim_reg <= delim_next;
            len_reg   <= len_next;
            limit_reg <= limit_next;
        end
    end

    // Zero length acts as one, anything above the window depth saturates
    always_comb
    begin
        cfg.delim = delim_reg;
        cfg.limit = limit_reg;
        if (len_reg == '0)
            cfg.len = LEN_W'(1);
        else if (len_reg > LEN_MAX)
            cfg.len = LEN_MAX;
        else
            cfg.len = len_reg;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dslim_step.sv -----
// dslim_step: lookahead window, match compare and split bookkeeping.
// Depends on dslim_pkg; produces at most one result word per cycle.
`timescale 1ns / 1ps
`default_nettype none

module dslim_step (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dslim_pkg::cfg_t              cfg,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [dslim_pkg::BYTE_W-1:0] byte_value,
    input  wire logic                         final_byte,
    input  wire logic                         out_free,
    output logic                              res_push,
    output dslim_pkg::res_t                   res
);
    import dslim_pkg::*;

    logic [BYTE_W-1:0]  win_reg  [MAX_DELIMITER];
    logic [BYTE_W-1:0]  win_next [MAX_DELIMITER];
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [LIMIT_W-1:0] splits_reg, splits_next;
    logic               nonempty_reg, nonempty_next;
    logic               busy_reg, busy_next;
    logic               last_reg, last_next;

    logic [MAX_DELIMITER-1:0] byte_eq;
    logic active, matched, act_a, act_b, more_a;
    logic do_match, do_emit, do_pe, finish, fire, step_end, accept;

    // Parallel window compare; positions past the delimiter length always agree
    always_comb
    begin
        for (int i = 0; i < MAX_DELIMITER; i++)
        begin
            byte_eq[i] = (win_reg[i] == cfg.delim[i*BYTE_W +: BYTE_W])
                         || (LEN_W'(i) >= cfg.len);
        end
        matched = &byte_eq;
    end

    // Decide this cycle's action for the word in progress
    always_comb
    begin
        active   = (cfg.limit == '0) || (splits_reg < cfg.limit);
        act_a    = active ? (fill_reg >= FILL_W'(cfg.len)) : (fill_reg != '0);
        act_b    = last_reg && ((fill_reg != '0) || nonempty_reg);
        more_a   = active ? (fill_reg > FILL_W'(cfg.len)) : (fill_reg > FILL_W'(1));
        do_match = act_a && active && (fill_reg == FILL_W'(cfg.len)) && matched;
        do_emit  = act_a ? !do_match : (act_b && (fill_reg != '0));
        do_pe    = do_match || (!act_a && act_b && (fill_reg == '0));
        // the flush of a final word always ends on a piece end
        finish   = act_a ? (!more_a && !(last_reg && do_emit)) : do_pe;
        fire     = busy_reg && (act_a || act_b) && out_free;
        step_end = !busy_reg || !(act_a || act_b) || (fire && finish);
        accept   = in_valid && step_end;
        in_stall = !step_end;

        res_push       = fire;
        res.out_byte   = do_emit ? win_reg[0] : '0;
        res.has_byte   = do_emit;
        res.piece_end  = do_pe;
        res.stream_end = last_reg && finish;
    end

    // Next state: apply the action, end-of-stream clear, then take the new byte
    always_comb
    begin
        win_next      = win_reg;
        fill_next     = fill_reg;
        splits_next   = splits_reg;
        nonempty_next = nonempty_reg;
        last_next     = last_reg;

        if (fire && do_emit)
        begin
            for (int i = 0; i < MAX_DELIMITER - 1; i++)
                win_next[i] = win_reg[i+1];
            fill_next     = fill_reg - FILL_W'(1);
            nonempty_next = 1'b1;
        end
        if (fire && do_match)
        begin
            fill_next     = '0;
            nonempty_next = 1'b0;
            if (splits_reg != SPLIT_SAT)
                splits_next = splits_reg + LIMIT_W'(1);
        end
        if (busy_reg && last_reg && step_end)
        begin
            fill_next     = '0;
            splits_next   = '0;
            nonempty_next = 1'b0;
        end

        if (accept)
        begin
            win_next[fill_next[WIN_IDX_W-1:0]] = byte_value;
            fill_next = fill_next + FILL_W'(1);
            last_next = final_byte;
            busy_next = 1'b1;
        end
        else
        begin
            busy_next = busy_reg && !step_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            splits_reg   <= '0;
            nonempty_reg <= 1'b0;
            busy_reg     <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            splits_reg   <= splits_next;
            nonempty_reg <= nonempty_next;
            busy_reg     <= busy_next;
            last_reg     <= last_next;
        end
    end

    // Window bytes are only read below the fill level
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dslim_outreg.sv -----
// dslim_outreg: result register between the splitting logic and the output.
// Depends on dslim_pkg; frees itself in the same cycle its word is taken.
`timescale 1ns / 1ps
`default_nettype none

module dslim_outreg (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_push,
    input  wire dslim_pkg::res_t res,
    output logic         out_free,
    output logic         out_valid,
    input  wire logic    out_stall,
    output dslim_pkg::res_t out_res
);
    import dslim_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    // Room for a new word when empty or when the held word leaves now
    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = res_push || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/delimiter_split_with_limit_core.sv -----
// delimiter_split_with_limit_core: top level of the delimiter splitter.
// Depends on dslim_pkg, dslim_cfg, dslim_step and dslim_outreg.
`timescale 1ns / 1ps
`default_nettype none

// Splits a byte stream at a delimiter of one to eight bytes held in the
// configuration registers, leftmost first and without overlap, with an
// optional limit on the number of splits. One byte enters per clock while
// the output is not stalled and the previous word has no results left,
// and each cycle sends at most one result word through the single output
// register. An input word that causes more than one result keeps in_stall
// high until its last result is sent; this happens on the final byte
// (the window is flushed, up to eight bytes plus the closing piece end),
// after the split limit is reached with bytes still held, and after the
// delimiter length is shortened with bytes held. Words causing no result
// do not stall the input. Configuration writes are always accepted and
// must only be made while the block is idle.
module delimiter_split_with_limit_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dslim_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dslim_pkg::DELIM_W-1:0]   cfg_data,
    // input byte channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [dslim_pkg::BYTE_W-1:0]    byte_value,
    input  wire logic                            final_byte,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [dslim_pkg::BYTE_W-1:0]         out_byte,
    output logic                                 has_byte,
    output logic                                 piece_end,
    output logic                                 stream_end
);
    import dslim_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t out_res;
    logic res_push;
    logic out_free;

    // Configuration registers
    dslim_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Window and split logic
    dslim_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_value (byte_value),
        .final_byte (final_byte),
        .out_free   (out_free),
        .res_push   (res_push),
        .res        (res)
    );

    // Result register
    dslim_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign out_byte   = out_res.out_byte;
    assign has_byte   = out_res.has_byte;
    assign piece_end  = out_res.piece_end;
    assign stream_end = out_res.stream_end;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// testbench: self-checking bench for delimiter_split_with_limit_core, with a
// scoreboard class that predicts the split results from the accepted words.
// Depends on dslim_pkg and delimiter_split_with_limit_core.
`timescale 1ns / 1ps

import dslim_pkg::*;

// Predicts the result words of the splitter and checks the ones it returns
class split_scoreboard;
    logic [DELIM_W-1:0] delim_bytes;
    logic [LEN_W-1:0]   delim_len;
    logic [LIMIT_W-1:0] split_limit;
    logic [BYTE_W-1:0]  window [MAX_DELIMITER];
    int unsigned        fill;
    logic [LIMIT_W-1:0] splits;
    bit                 nonempty;
    int                 step_results;
    res_t               pending_results[$];
    int                 errors;

    function new();
        delim_bytes = '0;
        delim_len   = LEN_W'(1);
        split_limit = '0;
        errors      = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        foreach (window[i])
            window[i] = '0;
        fill     = 0;
        splits   = '0;
        nonempty = 1'b0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [DELIM_W-1:0] data);
        case (idx)
            REG_DELIM_BYTES:  delim_bytes = data;
            REG_DELIM_LENGTH: delim_len   = data[LEN_W-1:0];
            REG_SPLIT_LIMIT:  split_limit = data[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function void push_result(logic [BYTE_W-1:0] b, bit with_byte, bit closes);
        res_t r;
        r.out_byte   = b;
        r.has_byte   = with_byte;
        r.piece_end  = closes;
        r.stream_end = 1'b0;
        pending_results.push_back(r);
        step_results++;
    endfunction

    // oldest held byte leaves as a piece byte
    function void release_oldest();
        if (fill == 0)
            return;
        push_result(window[0], 1'b1, 1'b0);
        nonempty = 1'b1;
        for (int i = 1; i < fill; i++)
            window[i-1] = window[i];
        fill--;
    endfunction

    function bit window_is_delim(int unsigned len);
        for (int i = 0; i < len; i++)
            if (window[i] != delim_bytes[8*i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    // expected results of one accepted word
    function void note_byte(logic [BYTE_W-1:0] b, logic last);
        int unsigned len;
        bit          matching;
        res_t        r;
        step_results = 0;
        if (delim_len == 0)
            len = 1;
        else if (delim_len > MAX_DELIMITER)
            len = MAX_DELIMITER;
        else
            len = delim_len;
        matching = (split_limit == 0) || (splits < split_limit);

        if (fill >= MAX_DELIMITER)
            release_oldest();
        window[fill] = b;
        fill++;

        if (!matching)
        begin
            while (fill > 0)
                release_oldest();
        end
        else
        begin
            while (fill > len)
                release_oldest();
            if (fill == len)
            begin
                if (window_is_delim(len))
                begin
                    push_result('0, 1'b0, 1'b1);
                    fill     = 0;
                    nonempty = 1'b0;
                    if (splits != SPLIT_SAT)
                        splits++;
                end
                else
                begin
                    release_oldest();
                end
            end
        end

        // last byte: flush, close a non-empty piece, flag the stream end
        if (last)
        begin
            while (fill > 0)
                release_oldest();
            if (nonempty)
                push_result('0, 1'b0, 1'b1);
            if (step_results > 0)
            begin
                r = pending_results.pop_back();
                r.stream_end = 1'b1;
                pending_results.push_back(r);
            end
            clear_stream();
        end
    endfunction

    function void report(string field, int want, int got);
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
    endfunction

    function void check_result(res_t got);
        res_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t ns: result word with none expected, expected nothing, actual %h",
                     $time, got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (got.out_byte !== want.out_byte)
            report("out_byte", want.out_byte, got.out_byte);
        if (got.has_byte !== want.has_byte)
            report("has_byte", want.has_byte, got.has_byte);
        if (got.piece_end !== want.piece_end)
            report("piece_end", want.piece_end, got.piece_end);
        if (got.stream_end !== want.stream_end)
            report("stream_end", want.stream_end, got.stream_end);
    endfunction
endclass

module testbench;

    localparam int RANDOM_WORDS = 300;
    localparam int SETTLE       = 10;
    localparam int QUIET_LIMIT  = 2000;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [DELIM_W-1:0]   cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    byte_value = '0;
    logic                 final_byte = 1'b0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [BYTE_W-1:0]    out_byte;
    logic                 has_byte;
    logic                 piece_end;
    logic                 stream_end;

    split_scoreboard   sb = new();
    int                quiet_cycles = 0;
    int                words_sent   = 0;
    int                gap_pct      = 0;
    int                stall_pct    = 0;
    logic [BYTE_W-1:0] word_buf[$];
    logic [DELIM_W-1:0] gen_delim;
    int                gen_len;

    delimiter_split_with_limit_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_value (byte_value),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .piece_end  (piece_end),
        .stream_end (stream_end)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver stall bursts
    always
    begin : stall_bursts
        int span;
        @(negedge clk);
        if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            span = $urandom_range(1, 8);
            out_stall <= 1'b1;
            repeat (span) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    // handshake monitor: note accepted words, check results, count quiet cycles
    always @(posedge clk)
    begin : monitor
        res_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_byte(byte_value, final_byte);
            if (out_valid && !out_stall)
            begin
                got.out_byte   = out_byte;
                got.has_byte   = has_byte;
                got.piece_end  = piece_end;
                got.stream_end = stream_end;
                sb.check_result(got);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // watchdog
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_word(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = 0;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 8);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        byte_value <= b;
        final_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_buffer(input bit close);
        for (int i = 0; i < word_buf.size(); i++)
            send_word(word_buf[i], close && (i == word_buf.size() - 1));
    endtask

    // sender holds off until every expected word is back, then lets the block settle
    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [DELIM_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // small alphabet so that partial delimiter matches are common
    function automatic logic [BYTE_W-1:0] pick_symbol();
        if ($urandom_range(0, 3) == 0)
            return BYTE_W'($urandom);
        return BYTE_W'(8'h61 + $urandom_range(0, 2));
    endfunction

    task automatic random_settings();
        cfg_reg_t           seq[3];
        logic [DELIM_W-1:0] data;
        logic [LEN_W-1:0]   len_code;
        logic [LIMIT_W-1:0] limit_code;
        int                 r;
        int                 start;
        seq = '{REG_DELIM_BYTES, REG_DELIM_LENGTH, REG_SPLIT_LIMIT};

        r = $urandom_range(0, 9);
        if (r == 0)
            gen_delim = '0;
        else if (r == 1)
            gen_delim = '1;
        else
            for (int i = 0; i < MAX_DELIMITER; i++)
                gen_delim[8*i +: 8] = pick_symbol();

        r = $urandom_range(0, 19);
        if (r == 0)
            len_code = '0;
        else if (r == 1)
            len_code = LEN_W'($urandom_range(MAX_DELIMITER + 1, 15));
        else
            len_code = LEN_W'($urandom_range(1, MAX_DELIMITER));
        gen_len = (len_code == 0) ? 1 : (len_code > MAX_DELIMITER ? MAX_DELIMITER : len_code);

        r = $urandom_range(0, 9);
        if (r < 4)
            limit_code = '0;
        else if (r < 8)
            limit_code = LIMIT_W'($urandom_range(1, 4));
        else if (r == 8)
            limit_code = SPLIT_SAT;
        else
            limit_code = LIMIT_W'($urandom);

        // every register, in rotated order; unused upper data bits sometimes set
        start = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++)
        begin
            data = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
            case (seq[(start + k) % 3])
                REG_DELIM_BYTES:  data = gen_delim;
                REG_DELIM_LENGTH: data[LEN_W-1:0] = len_code;
                REG_SPLIT_LIMIT:  data[LIMIT_W-1:0] = limit_code;
                default: ;
            endcase
            write_register(seq[(start + k) % 3], data);
        end
    endtask

    // fills word_buf with pieces joined by the delimiter, or with noise
    task automatic build_stream();
        int pieces;
        int span;
        word_buf.delete();
        if ($urandom_range(0, 99) < 15)
        begin
            span = $urandom_range(1, 20);
            repeat (span) word_buf.push_back(BYTE_W'($urandom));
        end
        else
        begin
            pieces = $urandom_range(1, 5);
            for (int p = 0; p < pieces; p++)
            begin
                span = $urandom_range(0, 6);
                repeat (span)
                begin
                    if ($urandom_range(0, 9) < 6)
                        word_buf.push_back(gen_delim[8*$urandom_range(0, gen_len - 1) +: 8]);
                    else
                        word_buf.push_back(BYTE_W'($urandom));
                end
                if (p < pieces - 1 || $urandom_range(0, 2) == 0)
                begin
                    // broken delimiter now and then
                    span = ($urandom_range(0, 9) == 0) ?
                           $urandom_range(0, gen_len - 1) : gen_len;
                    for (int i = 0; i < span; i++)
                        word_buf.push_back(gen_delim[8*i +: 8]);
                end
            end
        end
        if (word_buf.size() == 0)
            word_buf.push_back(pick_symbol());
    endtask

    task automatic random_phase(input bit keep_open_allowed);
        int streams;
        random_settings();
        streams = $urandom_range(1, 4);
        for (int s = 0; s < streams; s++)
        begin
            build_stream();
            send_buffer(s < streams - 1 || !keep_open_allowed || $urandom_range(0, 3) != 0);
        end
        pause_until_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        gap_pct   = 20;
        stall_pct = 20;

        // reset settings: single zero byte delimiter, consecutive ones give empty pieces
        word_buf = '{8'h00, 8'h00, 8'h80};
        send_buffer(1'b0);
        send_word(8'h00, 1'b1);
        pause_until_drained();

        // all-ones delimiter, length code above the maximum, largest limit
        write_register(REG_DELIM_BYTES, '1);
        write_register(REG_DELIM_LENGTH, DELIM_W'(15));
        write_register(REG_SPLIT_LIMIT, DELIM_W'(SPLIT_SAT));
        repeat (MAX_DELIMITER) send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        pause_until_drained();

        // length code zero acts as one (upper data bits ignored); limit of one split
        write_register(REG_DELIM_BYTES, DELIM_W'(64'h2C));
        write_register(REG_DELIM_LENGTH, {{(DELIM_W-LEN_W){1'b1}}, {LEN_W{1'b0}}});
        write_register(REG_SPLIT_LIMIT, DELIM_W'(1));
        word_buf = '{8'h2C, 8'h2C};
        send_buffer(1'b0);
        send_word(8'h41, 1'b1);
        pause_until_drained();

        // limit lowered mid-stream with bytes held: they pass straight through
        write_register(REG_DELIM_BYTES, DELIM_W'(64'h434241));
        write_register(REG_DELIM_LENGTH, DELIM_W'(3));
        write_register(REG_SPLIT_LIMIT, '0);
        word_buf = '{8'h41, 8'h42, 8'h43, 8'h41, 8'h42};
        send_buffer(1'b0);
        pause_until_drained();
        write_register(REG_SPLIT_LIMIT, DELIM_W'(1));
        send_word(8'h5A, 1'b1);
        pause_until_drained();

        // delimiter shortened mid-stream with bytes held
        word_buf = '{8'h41, 8'h42};
        send_buffer(1'b0);
        pause_until_drained();
        write_register(REG_DELIM_LENGTH, DELIM_W'(1));
        send_word(8'h42, 1'b1);
        pause_until_drained();

        // random settings and streams, with varying idling on both sides
        while (words_sent < 25 + RANDOM_WORDS)
        begin
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            random_phase(1'b1);
        end

        // closing stretch with no idling
        gap_pct   = 0;
        stall_pct = 0;
        random_phase(1'b0);
        random_phase(1'b0);

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- delimiter_split_with_limit_core.f -----
hw/rtl/dslim_pkg.sv
hw/rtl/dslim_cfg.sv
hw/rtl/dslim_step.sv
hw/rtl/dslim_outreg.sv
hw/rtl/delimiter_split_with_limit_core.sv
verif/testbench.sv
